// ----- hw/rtl/psb_pkg.sv -----
// shared types and constants for the palette sprite row blitter
package psb_pkg;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_DRAW = 1'b1
  } req_e;

  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned ADDR_W    = 17;
  localparam int unsigned MAP_W     = 16;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned BITS_W    = 32;
  localparam int unsigned SHADE_W   = 4;
  localparam int unsigned PAL_IDX_W = 4;
  localparam int unsigned PAL_SEL_W = 1;
  localparam int unsigned SLOTS     = 32;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned COL_W     = 4;
  localparam int unsigned DX_W      = 18;
  localparam int unsigned X_W       = 20;
  localparam int unsigned LINE_W    = 17;

  localparam logic [MAP_W-1:0]   MAP_WIDTH_RST = 16'd1024;
  localparam logic [SHADE_W-1:0] SHADE_CLEAR   = 4'h0;

  typedef struct packed {
    req_e                        kind;
    logic [PAL_SEL_W-1:0]        sel;
    logic [PAL_IDX_W-1:0]        idx;
    logic [COLOR_W-1:0]          color;
    logic [BITS_W-1:0]           bits;
    logic                        mirror;
    logic signed [X_W-2:0]       base_x;
    logic signed [LINE_W-1:0]    top;
    logic [ADDR_W-1:0]           top_addr;
  } psb_row_t;

  typedef struct packed {
    req_e                        kind;
    logic [PAL_SEL_W-1:0]        sel;
    logic [PAL_IDX_W-1:0]        idx;
    logic [COLOR_W-1:0]          color;
    logic [SHADE_W-1:0]          shade;
    logic                        vis;
    logic [ADDR_W-1:0]           col_addr;
    logic [ADDR_W-1:0]           line_addr;
    logic                        last;
  } psb_slot_t;

endpackage

// ----- hw/rtl/psb_req_if.sv -----
// request channel: palette loads and sprite row draws
interface psb_req_if;
  import psb_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [PAL_SEL_W-1:0]        palette_select;
  logic [PAL_IDX_W-1:0]        palette_index;
  logic [COLOR_W-1:0]          palette_color;
  logic [ROW_W-1:0]            row_index;
  logic [BITS_W-1:0]           row_bits;
  logic signed [COORD_W-1:0]   sprite_x;
  logic signed [COORD_W-1:0]   camera_x;
  logic signed [COORD_W-1:0]   sprite_y;
  logic                        mirror;

  modport source (
    output valid, req_type, palette_select, palette_index, palette_color,
           row_index, row_bits, sprite_x, camera_x, sprite_y, mirror,
    input  ready
  );

  modport sink (
    input  valid, req_type, palette_select, palette_index, palette_color,
           row_index, row_bits, sprite_x, camera_x, sprite_y, mirror,
    output ready
  );
endinterface

// ----- hw/rtl/psb_pix_if.sv -----
// pixel write slot channel towards the framebuffer
interface psb_pix_if;
  import psb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 write_enable;
  logic [ADDR_W-1:0]    pixel_address;
  logic [COLOR_W-1:0]   pixel_color;
  logic                 last;

  modport source (
    output valid, write_enable, pixel_address, pixel_color, last,
    input  ready
  );

  modport sink (
    input  valid, write_enable, pixel_address, pixel_color, last,
    output ready
  );
endinterface

// ----- hw/rtl/psb_front.sv -----
// front pipeline: request register, camera-relative x with wrap, line base address
module psb_front #(
  parameter int SCREEN_W = 320
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [psb_pkg::MAP_W-1:0]   map_width_i,
  psb_req_if.sink                     req_i,
  output logic                        row_valid_o,
  input  logic                        row_ready_i,
  output psb_pkg::psb_row_t           row_o
);
  import psb_pkg::*;

  localparam logic signed [X_W-2:0] HalfScreen = (X_W-1)'(SCREEN_W / 2);
  localparam logic [ADDR_W-1:0]     ScreenWAddr = ADDR_W'(SCREEN_W);

  typedef struct packed {
    req_e                        kind;
    logic [PAL_SEL_W-1:0]        sel;
    logic [PAL_IDX_W-1:0]        idx;
    logic [COLOR_W-1:0]          color;
    logic [ROW_W-1:0]            row;
    logic [BITS_W-1:0]           bits;
    logic signed [COORD_W-1:0]   spx;
    logic signed [COORD_W-1:0]   camx;
    logic signed [COORD_W-1:0]   spy;
    logic                        mirror;
  } req_t;

  logic                       s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic                       s1_rdy, s2_rdy, s3_rdy, s4_rdy;
  req_t                       s1_q;
  psb_row_t                   s2_q, s3_q, s4_q;
  psb_row_t                   s2_d, s3_d, s4_d;
  logic signed [LINE_W-1:0]   s2_dx_q, s2_dx_d;
  logic signed [DX_W-1:0]     s3_dx_q, s3_dx_d;
  logic signed [DX_W-1:0]     width_s, half_s, dx_ext, dx_fix;

  assign s4_rdy = !s4_v_q || row_ready_i;
  assign s3_rdy = !s3_v_q || s4_rdy;
  assign s2_rdy = !s2_v_q || s3_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;

  assign req_i.ready = s1_rdy;
  assign row_valid_o = s4_v_q;
  assign row_o       = s4_q;

  assign width_s = $signed({2'b00, map_width_i});
  assign half_s  = $signed({3'b000, map_width_i[MAP_W-1:1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= req_i.valid;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
      if (s4_rdy) s4_v_q <= s3_v_q;
    end
  end

  // stage 2: raw x distance and top line of this row
  always_comb begin
    s2_d          = '0;
    s2_d.kind     = s1_q.kind;
    s2_d.sel      = s1_q.sel;
    s2_d.idx      = s1_q.idx;
    s2_d.color    = s1_q.color;
    s2_d.bits     = s1_q.bits;
    s2_d.mirror   = s1_q.mirror;
    s2_d.top      = $signed({s1_q.spy[COORD_W-1], s1_q.spy})
                  + $signed({{(LINE_W-ROW_W-1){1'b0}}, s1_q.row, 1'b0});
    s2_dx_d       = $signed({s1_q.spx[COORD_W-1], s1_q.spx})
                  - $signed({s1_q.camx[COORD_W-1], s1_q.camx});
  end

  // stage 3: first wrap step and line base address modulo the address width
  always_comb begin
    dx_ext        = $signed({s2_dx_q[LINE_W-1], s2_dx_q});
    s3_d          = s2_q;
    s3_d.top_addr = $unsigned(s2_q.top) * ScreenWAddr;
    s3_dx_d       = (dx_ext > half_s) ? dx_ext - width_s : dx_ext;
  end

  // stage 4: second wrap step and screen base x
  always_comb begin
    dx_fix        = (s3_dx_q < -half_s) ? s3_dx_q + width_s : s3_dx_q;
    s4_d          = s3_q;
    s4_d.base_x   = $signed({dx_fix[DX_W-1], dx_fix}) + HalfScreen;
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && req_i.valid) begin
      s1_q.kind   <= req_e'(req_i.req_type);
      s1_q.sel    <= req_i.palette_select;
      s1_q.idx    <= req_i.palette_index;
      s1_q.color  <= req_i.palette_color;
      s1_q.row    <= req_i.row_index;
      s1_q.bits   <= req_i.row_bits;
      s1_q.spx    <= req_i.sprite_x;
      s1_q.camx   <= req_i.camera_x;
      s1_q.spy    <= req_i.sprite_y;
      s1_q.mirror <= req_i.mirror;
    end
    if (s2_rdy && s1_v_q) begin
      s2_q    <= s2_d;
      s2_dx_q <= s2_dx_d;
    end
    if (s3_rdy && s2_v_q) begin
      s3_q    <= s3_d;
      s3_dx_q <= s3_dx_d;
    end
    if (s4_rdy && s3_v_q) begin
      s4_q    <= s4_d;
    end
  end

endmodule

// ----- hw/rtl/psb_slot.sv -----
// slot sequencer: expands a draw row into 32 slots and a load into a single slot, shade pick and visibility per slot
module psb_slot #(
  parameter int SCREEN_W = 320,
  parameter int SCREEN_H = 240
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 row_valid_i,
  output logic                 row_ready_o,
  input  psb_pkg::psb_row_t    row_i,
  output logic                 slot_valid_o,
  input  logic                 slot_ready_i,
  output psb_pkg::psb_slot_t   slot_o
);
  import psb_pkg::*;

  localparam logic [ADDR_W-1:0] ScreenWAddr = ADDR_W'(SCREEN_W);
  localparam logic [X_W-1:0]    ScreenWX    = X_W'(SCREEN_W);
  localparam logic [LINE_W-1:0] ScreenHLine = LINE_W'(SCREEN_H);
  localparam logic [SLOT_W-1:0] LastSlot    = SLOT_W'(SLOTS - 1);

  logic                       hold_v_q;
  psb_row_t                   hold_q;
  logic [SLOT_W-1:0]          cnt_q;
  logic                       out_v_q;
  psb_slot_t                  out_q, out_d;
  logic                       out_rdy, emit, done, take;
  logic [COL_W-1:0]           col;
  logic [2:0]                 nib;
  logic signed [X_W-1:0]      sx;
  logic signed [LINE_W-1:0]   line;

  assign out_rdy     = !out_v_q || slot_ready_i;
  assign emit        = hold_v_q && out_rdy;
  assign done        = emit && ((hold_q.kind == REQ_LOAD) || (cnt_q == LastSlot));
  assign row_ready_o = !hold_v_q || done;
  assign take        = row_valid_i && row_ready_o;

  assign slot_valid_o = out_v_q;
  assign slot_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      cnt_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      if (row_ready_o) hold_v_q <= row_valid_i;
      if (take) begin
        cnt_q <= '0;
      end else if (emit) begin
        cnt_q <= cnt_q + SLOT_W'(1);
      end
      if (out_rdy) out_v_q <= hold_v_q;
    end
  end

  always_comb begin
    col  = cnt_q[COL_W-1:0];
    // mirrored shade index is 7 minus the plain one
    nib  = hold_q.mirror ? ~col[COL_W-1:1] : col[COL_W-1:1];
    sx   = $signed({hold_q.base_x[X_W-2], hold_q.base_x})
         + $signed({{(X_W-COL_W){1'b0}}, col});
    line = hold_q.top + $signed({{(LINE_W-1){1'b0}}, cnt_q[SLOT_W-1]});

    out_d           = '0;
    out_d.kind      = hold_q.kind;
    out_d.sel       = hold_q.sel;
    out_d.idx       = hold_q.idx;
    out_d.color     = hold_q.color;
    out_d.shade     = hold_q.bits[{~nib, 2'b00} +: SHADE_W];
    out_d.vis       = !line[LINE_W-1] && ($unsigned(line) < ScreenHLine)
                   && !sx[X_W-1] && ($unsigned(sx) < ScreenWX);
    out_d.col_addr  = $unsigned(sx[ADDR_W-1:0]);
    out_d.line_addr = hold_q.top_addr + (cnt_q[SLOT_W-1] ? ScreenWAddr : '0);
    out_d.last      = (hold_q.kind == REQ_DRAW) && (cnt_q == LastSlot);
  end

  always_ff @(posedge clk_i) begin
    if (take) hold_q <= row_i;
    if (emit) out_q  <= out_d;
  end

endmodule

// ----- hw/rtl/psb_pixel.sv -----
// palette store and pixel slot output register
module psb_pixel (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 slot_valid_i,
  output logic                 slot_ready_o,
  input  psb_pkg::psb_slot_t   slot_i,
  psb_pix_if.source            pix_o
);
  import psb_pkg::*;

  localparam int unsigned PalDepth = 2 ** (PAL_SEL_W + PAL_IDX_W);

  logic [COLOR_W-1:0]  pal_q [PalDepth];
  logic                out_v_q;
  logic                we_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [COLOR_W-1:0]  color_q;
  logic                last_q;
  logic                out_rdy, take, enable;

  assign out_rdy      = !out_v_q || pix_o.ready;
  assign slot_ready_o = out_rdy;
  assign take         = slot_valid_i && out_rdy;
  assign enable       = slot_i.vis && (slot_i.shade != SHADE_CLEAR);

  assign pix_o.valid         = out_v_q;
  assign pix_o.write_enable  = we_q;
  assign pix_o.pixel_address = addr_q;
  assign pix_o.pixel_color   = color_q;
  assign pix_o.last          = last_q;

  // loads write here, in order with the reads of earlier draws
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PalDepth; i++) begin
        pal_q[i] <= '0;
      end
      out_v_q <= 1'b0;
    end else begin
      if (take && (slot_i.kind == REQ_LOAD)) begin
        pal_q[{slot_i.sel, slot_i.idx}] <= slot_i.color;
      end
      if (out_rdy) out_v_q <= slot_valid_i && (slot_i.kind == REQ_DRAW);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && (slot_i.kind == REQ_DRAW)) begin
      we_q    <= enable;
      addr_q  <= enable ? slot_i.col_addr + slot_i.line_addr : '0;
      color_q <= enable ? pal_q[{slot_i.sel, slot_i.shade}] : '0;
      last_q  <= slot_i.last;
    end
  end

endmodule

// ----- hw/rtl/palette_sprite_row_blitter_top.sv -----
// top level of the palette sprite row blitter
//
//  channel   dir  handshake            payload
//  req_i     in   valid / ready        palette load or sprite row draw request
//  pix_o     out  valid / ready        pixel write slot (enable, address, colour, last)
//  cfg       in   cfg_we_i             map width, cfg_wdata_i
//
// a draw request gives 32 slots, one per cycle from the slot sequencer while the
// pixel stage is not stalled; a palette load gives no pixel write slot.
// requests pass the request register, stages 2 to 4, row hold, slot and pixel registers.
// reset clears the palette to zero and sets the map width to 1024 at once.
// every stage holds its contents while the next one is stalled.
module palette_sprite_row_blitter_top #(
  parameter int SCREEN_W = 320,
  parameter int SCREEN_H = 240
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [psb_pkg::MAP_W-1:0]   cfg_wdata_i,
  psb_req_if.sink                     req_i,
  psb_pix_if.source                   pix_o
);
  import psb_pkg::*;

  logic [MAP_W-1:0]  map_width_q;
  logic              row_valid, row_ready;
  psb_row_t          row;
  logic              slot_valid, slot_ready;
  psb_slot_t         slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q <= MAP_WIDTH_RST;
    end else if (cfg_we_i) begin
      map_width_q <= cfg_wdata_i;
    end
  end

  psb_front #(
    .SCREEN_W (SCREEN_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .map_width_i (map_width_q),
    .req_i       (req_i),
    .row_valid_o (row_valid),
    .row_ready_i (row_ready),
    .row_o       (row)
  );

  psb_slot #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_slot (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_valid_i  (row_valid),
    .row_ready_o  (row_ready),
    .row_i        (row),
    .slot_valid_o (slot_valid),
    .slot_ready_i (slot_ready),
    .slot_o       (slot)
  );

  psb_pixel u_pixel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slot_valid_i (slot_valid),
    .slot_ready_o (slot_ready),
    .slot_i       (slot),
    .pix_o        (pix_o)
  );

  // a masked slot carries neither address nor colour
  a_masked_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid && !pix_o.write_enable |-> pix_o.pixel_address == '0 && pix_o.pixel_color == '0)
    else $error("masked slot with nonzero address or colour");

  a_row_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_valid && !row_ready |=> row_valid && $stable(row))
    else $error("row request lost or changed while stalled");

  a_slot_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_valid && !slot_ready |=> slot_valid && $stable(slot))
    else $error("slot lost or changed while stalled");

  // the final slot of a row always comes from a draw
  a_last_is_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_valid && slot.last |-> slot.kind == REQ_DRAW)
    else $error("last flag on a palette load");

endmodule
